[rtl/core/decimal_seven_segment_formatter_assert.svh]
// Assertion macros for the decimal seven-segment formatter.
// Expects clk and rst_n in the scope of the including module.
`ifndef DECIMAL_SEVEN_SEGMENT_FORMATTER_ASSERT_SVH
`define DECIMAL_SEVEN_SEGMENT_FORMATTER_ASSERT_SVH

// Same-cycle implication under reset.
`define DSF_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dsf assertion failed");

// Next-cycle implication under reset.
`define DSF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dsf assertion failed");

`endif

[rtl/core/dsf_pkg.sv]
// Package for the decimal seven-segment formatter: widths, limits, state type
// and the digit-to-segment table. No dependencies.
package dsf_pkg;

  localparam int VALUE_W    = 28;
  localparam int START_W    = 4;
  localparam int GRID_W     = 4;
  localparam int SEG_W      = 8;
  localparam int MAG_W      = 27;
  localparam int BCD_DIGITS = 8;
  localparam int BCD_W      = 4 * BCD_DIGITS;
  localparam int CNT_W      = $clog2(MAG_W);

  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 28'sd99999999;
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = -28'sd9999999;

  localparam logic [SEG_W-1:0] PATTERN_MINUS = 8'h40;
  localparam logic [SEG_W-1:0] PATTERN_BLANK = 8'h00;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } conv_status_t;

  function automatic logic [SEG_W-1:0] seg_of_digit(input logic [3:0] d);
    logic [SEG_W-1:0] p;
    case (d)
      4'd0: p = 8'h3f;
      4'd1: p = 8'h06;
      4'd2: p = 8'h5b;
      4'd3: p = 8'h4f;
      4'd4: p = 8'h66;
      4'd5: p = 8'h6d;
      4'd6: p = 8'h7d;
      4'd7: p = 8'h07;
      4'd8: p = 8'h7f;
      4'd9: p = 8'h6f;
      default: p = PATTERN_BLANK;
    endcase
    return p;
  endfunction

endpackage

[rtl/core/dsf_bin2bcd.sv]
// Binary to BCD converter: one shift-and-add-3 step per cycle, MAG_W steps in all.
// Depends on dsf_pkg.
module dsf_bin2bcd (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [dsf_pkg::MAG_W-1:0]     mag,
  output dsf_pkg::conv_status_t         status,
  output logic [dsf_pkg::BCD_W-1:0]     bcd
);

  logic [dsf_pkg::MAG_W-1:0] mag_r;
  logic [dsf_pkg::BCD_W-1:0] bcd_r;
  logic [dsf_pkg::BCD_W-1:0] adj;
  logic [dsf_pkg::CNT_W-1:0] cnt_r;
  logic                      busy_r;
  logic                      done_r;
  logic                      last_step;

  always_comb begin
    for (int j = 0; j < dsf_pkg::BCD_DIGITS; j++) begin
      if (bcd_r[j*4 +: 4] >= 4'd5) begin
        adj[j*4 +: 4] = bcd_r[j*4 +: 4] + 4'd3;
      end else begin
        adj[j*4 +: 4] = bcd_r[j*4 +: 4];
      end
    end
  end

  assign last_step = (cnt_r == dsf_pkg::CNT_W'(dsf_pkg::MAG_W - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && last_step;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last_step) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag_r <= mag;
      bcd_r <= '0;
    end else if (busy_r) begin
      mag_r <= {mag_r[dsf_pkg::MAG_W-2:0], 1'b0};
      bcd_r <= {adj[dsf_pkg::BCD_W-2:0], mag_r[dsf_pkg::MAG_W-1]};
    end
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign bcd         = bcd_r;

endmodule

[rtl/core/decimal_seven_segment_formatter.sv]
// Top level of the decimal seven-segment formatter: accept, sequencer, emit.
// Depends on dsf_pkg, dsf_bin2bcd and decimal_seven_segment_formatter_assert.svh.
//
// channel | direction | handshake             | fields
// in      | input     | in_valid / in_stall   | in_value, in_start_position
// out     | output    | out_valid / out_stall | out_grid_position, out_segment_pattern,
//         |           |                       | out_last_digit
//
// An accepted in-range item passes from idle into the shift-and-add-3 converter
// and then steps through the DIGIT_COUNT display digit slots in order, each
// slot waiting while the output register is stalled.
// A rejected item is dropped in the cycle it is accepted.
// Reset clears the sequencer, the output valid and the blanking flag.
// in_stall is high from an accepted in-range item until its last result is loaded.
module decimal_seven_segment_formatter #(
  parameter int DIGIT_COUNT = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [dsf_pkg::VALUE_W-1:0] in_value,
  input  logic [dsf_pkg::START_W-1:0]       in_start_position,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [dsf_pkg::GRID_W-1:0]        out_grid_position,
  output logic [dsf_pkg::SEG_W-1:0]         out_segment_pattern,
  output logic                              out_last_digit
);

  `include "decimal_seven_segment_formatter_assert.svh"

  localparam int SW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam logic [SW-1:0] LAST_SLOT = SW'(DIGIT_COUNT - 1);

  dsf_pkg::state_t state_r, state_nxt;

  logic                          in_accept;
  logic                          in_range;
  logic                          conv_start;
  logic signed [dsf_pkg::VALUE_W-1:0] neg_value;
  logic [dsf_pkg::MAG_W-1:0]     mag;
  dsf_pkg::conv_status_t         conv_status;
  logic [dsf_pkg::BCD_W-1:0]     bcd;

  logic                          armed_r;
  logic                          neg_r;
  logic                          lead_r;
  logic [dsf_pkg::GRID_W-1:0]    base_r;
  logic [dsf_pkg::GRID_W-1:0]    ofs_r;
  logic [SW-1:0]                 slot_r;

  logic [3:0]                    digit_arr [DIGIT_COUNT];
  logic [SW-1:0]                 digit_idx;
  logic [3:0]                    digit;
  logic                          can_load;
  logic                          step;
  logic                          skip;
  logic                          blank;
  logic                          emit_now;
  logic [dsf_pkg::SEG_W-1:0]     pattern;

  logic                          out_valid_r;
  logic [dsf_pkg::GRID_W-1:0]    out_grid_r;
  logic [dsf_pkg::SEG_W-1:0]     out_seg_r;
  logic                          out_last_r;

  assign in_stall   = (state_r != dsf_pkg::ST_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign in_range   = (in_value <= dsf_pkg::VALUE_MAX) && (in_value >= dsf_pkg::VALUE_MIN);
  assign conv_start = in_accept && in_range;
  assign neg_value  = -in_value;
  assign mag        = in_value[dsf_pkg::VALUE_W-1] ? neg_value[dsf_pkg::MAG_W-1:0]
                                                   : in_value[dsf_pkg::MAG_W-1:0];

  dsf_bin2bcd u_bin2bcd (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (conv_start),
    .mag    (mag),
    .status (conv_status),
    .bcd    (bcd)
  );

  for (genvar j = 0; j < DIGIT_COUNT; j++) begin : g_digit
    if (j < dsf_pkg::BCD_DIGITS) begin : g_bcd
      assign digit_arr[j] = bcd[j*4 +: 4];
    end else begin : g_zero
      assign digit_arr[j] = 4'd0;
    end
  end

  assign digit_idx = LAST_SLOT - slot_r;
  assign digit     = digit_arr[digit_idx];
  assign can_load  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    step      = 1'b0;
    skip      = 1'b0;
    blank     = 1'b0;
    pattern   = dsf_pkg::seg_of_digit(digit);
    case (state_r)
      dsf_pkg::ST_IDLE: begin
        if (conv_start) begin
          state_nxt = dsf_pkg::ST_CONVERT;
        end
      end
      dsf_pkg::ST_CONVERT: begin
        if (conv_status.done) begin
          state_nxt = dsf_pkg::ST_EMIT;
        end
      end
      dsf_pkg::ST_EMIT: begin
        step = can_load;
        if (neg_r) begin
          if (slot_r == '0) begin
            pattern = dsf_pkg::PATTERN_MINUS;
          end else if (lead_r && digit == 4'd0 && slot_r != LAST_SLOT) begin
            blank   = 1'b1;
            pattern = dsf_pkg::PATTERN_BLANK;
          end
        end else if (lead_r && digit == 4'd0 && slot_r != LAST_SLOT) begin
          skip = 1'b1;
        end
        if (step && slot_r == LAST_SLOT) begin
          state_nxt = dsf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dsf_pkg::ST_IDLE;
      end
    endcase
  end

  assign emit_now = step && !skip;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dsf_pkg::ST_IDLE;
      armed_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (conv_start) begin
        armed_r <= 1'b1;
      end
      if (emit_now) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (conv_start) begin
      neg_r  <= in_value[dsf_pkg::VALUE_W-1];
      lead_r <= armed_r;
      base_r <= in_start_position - 1'b1;
      ofs_r  <= '0;
      slot_r <= '0;
    end else if (step) begin
      slot_r <= slot_r + 1'b1;
      if (!skip && !blank && !(neg_r && slot_r == '0)) begin
        lead_r <= 1'b0;
      end
      if (emit_now) begin
        ofs_r <= ofs_r + 1'b1;
      end
    end
    if (emit_now) begin
      out_grid_r <= base_r + ofs_r;
      out_seg_r  <= pattern;
      out_last_r <= (slot_r == LAST_SLOT);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_grid_position   = out_grid_r;
  assign out_segment_pattern = out_seg_r;
  assign out_last_digit      = out_last_r;

  `DSF_ASSERT_IMPL(a_done_in_convert, conv_status.done, state_r == dsf_pkg::ST_CONVERT)
  `DSF_ASSERT_NEXT(a_start_converts, conv_start, state_r == dsf_pkg::ST_CONVERT)
  `DSF_ASSERT_IMPL(a_emit_only_in_emit, emit_now, state_r == dsf_pkg::ST_EMIT && can_load)
  `DSF_ASSERT_NEXT(a_last_ends_item, emit_now && slot_r == LAST_SLOT,
                   state_r == dsf_pkg::ST_IDLE && out_last_digit)

endmodule

[verif/decimal_seven_segment_formatter_tb.sv]
// Testbench for decimal_seven_segment_formatter: directed and random display values,
// checked digit write by digit write against an in-bench predictor.
// Depends on dsf_pkg and the formatter RTL only.
module decimal_seven_segment_formatter_tb;

  localparam int DIGIT_COUNT = 8;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 60;
  localparam int TOTAL_ITEMS = 270;
  localparam int LONG_HOLD = 400;

  localparam logic [dsf_pkg::SEG_W-1:0] DIGIT_SEGMENTS [10] = '{
    8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
  };

  typedef struct packed {
    logic [dsf_pkg::GRID_W-1:0] grid;
    logic [dsf_pkg::SEG_W-1:0]  segments;
    logic                       last;
  } digit_write_t;

  typedef struct packed {
    logic signed [dsf_pkg::VALUE_W-1:0] value;
    logic [dsf_pkg::START_W-1:0]        start;
  } display_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [dsf_pkg::VALUE_W-1:0] in_value = '0;
  logic [dsf_pkg::START_W-1:0] in_start_position = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [dsf_pkg::GRID_W-1:0] out_grid_position;
  logic [dsf_pkg::SEG_W-1:0] out_segment_pattern;
  logic out_last_digit;

  display_item_t pending_items[$];
  digit_write_t expected_writes[$];
  digit_write_t front_write;
  logic blanking_on = 1'b0;

  int error_count = 0;
  int shown_count = 0;
  int rejected_count = 0;
  int writes_checked = 0;
  int send_gap = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit quiet_phase = 1'b0;
  int idle_cycles = 0;

  decimal_seven_segment_formatter #(
    .DIGIT_COUNT(DIGIT_COUNT)
  ) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_value           (in_value),
    .in_start_position  (in_start_position),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_grid_position  (out_grid_position),
    .out_segment_pattern(out_segment_pattern),
    .out_last_digit     (out_last_digit)
  );

  always #5 clk = ~clk;

  function automatic bit value_in_range(input logic signed [dsf_pkg::VALUE_W-1:0] value);
    return (value <= dsf_pkg::VALUE_MAX) && (value >= dsf_pkg::VALUE_MIN);
  endfunction

  task automatic predict_digit_writes(input logic signed [dsf_pkg::VALUE_W-1:0] value,
                                      input logic [dsf_pkg::START_W-1:0] start);
    int digits[DIGIT_COUNT];
    logic [dsf_pkg::SEG_W-1:0] segs[$];
    int v;
    int mag;
    int first;
    bit leading;
    digit_write_t w;
    v = value;
    if (!value_in_range(value)) begin
      rejected_count++;
      return;
    end
    shown_count++;
    if (v < 0) begin
      mag = -v;
      for (int i = DIGIT_COUNT - 2; i >= 0; i--) begin
        digits[i] = mag % 10;
        mag = mag / 10;
      end
      segs.push_back(dsf_pkg::PATTERN_MINUS);
      leading = blanking_on;
      for (int i = 0; i < DIGIT_COUNT - 1; i++) begin
        if (leading && digits[i] == 0 && i < DIGIT_COUNT - 2) begin
          segs.push_back(dsf_pkg::PATTERN_BLANK);
        end else begin
          leading = 1'b0;
          segs.push_back(DIGIT_SEGMENTS[digits[i]]);
        end
      end
    end else begin
      mag = v;
      for (int i = DIGIT_COUNT - 1; i >= 0; i--) begin
        digits[i] = mag % 10;
        mag = mag / 10;
      end
      first = 0;
      if (blanking_on) begin
        while (first < DIGIT_COUNT - 1 && digits[first] == 0) first++;
      end
      for (int i = first; i < DIGIT_COUNT; i++) segs.push_back(DIGIT_SEGMENTS[digits[i]]);
    end
    blanking_on = 1'b1;
    for (int i = 0; i < segs.size(); i++) begin
      w.grid = dsf_pkg::GRID_W'((int'(start) + 15 + i) % 16);
      w.segments = segs[i];
      w.last = (i == segs.size() - 1);
      expected_writes.push_back(w);
    end
  endtask

  function automatic int pick_idle_len();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(12, 48);
  endfunction

  function automatic logic signed [dsf_pkg::VALUE_W-1:0] pick_value();
    int r;
    int v;
    r = $urandom_range(99);
    if (r < 35) v = int'($urandom_range(0, 109999998)) - 9999999;
    else if (r < 50) v = $urandom_range(0, 999);
    else if (r < 62) v = -int'($urandom_range(1, 999));
    else if (r < 74) begin
      v = $urandom_range(1, 9);
      repeat ($urandom_range(0, 7)) v = v * 10;
      if (v > 9999999 && $urandom_range(1) == 1) v = v / 10;
      if ($urandom_range(2) == 0 && v <= 9999999) v = -v;
    end else if (r < 88) v = $urandom();
    else begin
      case ($urandom_range(5))
        0: v = 99999999;
        1: v = -9999999;
        2: v = 0;
        3: v = 100000000;
        4: v = -10000000;
        default: v = int'($urandom_range(0, 9)) - 5;
      endcase
    end
    return dsf_pkg::VALUE_W'(v);
  endfunction

  function automatic logic [dsf_pkg::START_W-1:0] pick_start();
    if ($urandom_range(4) == 0) return dsf_pkg::START_W'($urandom_range(0, 15));
    return dsf_pkg::START_W'($urandom_range(1, DIGIT_COUNT));
  endfunction

  task automatic queue_item(input int value, input int start);
    display_item_t item;
    item.value = dsf_pkg::VALUE_W'(value);
    item.start = dsf_pkg::START_W'(start);
    pending_items.push_back(item);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_digit_writes(in_value, in_start_position);
        quiet_phase <= (shown_count >= 150) && (shown_count < 190);
      end
      if (!(in_valid && in_stall)) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_value <= pending_items[0].value;
          in_start_position <= pending_items[0].start;
          void'(pending_items.pop_front());
          in_valid <= 1'b1;
          send_gap <= quiet_phase ? 0 : pick_idle_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        writes_checked++;
        if (expected_writes.size() == 0) begin
          $error("unexpected digit write: grid_position %0d segment_pattern %02h last_digit %0b",
                 out_grid_position, out_segment_pattern, out_last_digit);
          error_count++;
        end else begin
          front_write = expected_writes.pop_front();
          if (out_grid_position !== front_write.grid) begin
            $error("grid_position expected %0d actual %0d", front_write.grid, out_grid_position);
            error_count++;
          end
          if (out_segment_pattern !== front_write.segments) begin
            $error("segment_pattern expected %02h actual %02h",
                   front_write.segments, out_segment_pattern);
            error_count++;
          end
          if (out_last_digit !== front_write.last) begin
            $error("last_digit expected %0b actual %0b", front_write.last, out_last_digit);
            error_count++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (!hold_done && writes_checked >= 60) begin
        hold_done <= 1'b1;
        hold_left <= LONG_HOLD;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else if (!quiet_phase && $urandom_range(3) == 0) begin
        stall_left <= pick_idle_len();
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    display_item_t item;
    // rejected first value must not arm blanking
    queue_item(100000000, 1);
    queue_item(7, 1);
    queue_item(0, 1);
    queue_item(99999999, 1);
    queue_item(-9999999, 1);
    queue_item(-1, 1);
    queue_item(-10000000, 2);
    queue_item(134217727, 3);
    queue_item(-134217728, 4);
    queue_item(12345678, 1);
    queue_item(5, 8);
    queue_item(12345678, 9);
    queue_item(-1000, 0);
    queue_item(10000000, 15);
    queue_item(1000000, 3);
    queue_item(-9000000, 5);
    queue_item(-10, 8);
    queue_item(90000, 12);
    queue_item(0, 0);
    queue_item(-123456, 7);
    while (pending_items.size() < TOTAL_ITEMS) begin
      item.value = pick_value();
      item.start = pick_start();
      pending_items.push_back(item);
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    while (pending_items.size() > 0 || in_valid) @(negedge clk);
    while (expected_writes.size() > 0 || in_stall) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Shown %0d values and dropped %0d out-of-range values; checked %0d digit writes.",
             shown_count, rejected_count, writes_checked);
    $display("Starts 0..15, both signs, blanking depths and a long output hold were exercised.");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[decimal_seven_segment_formatter.f]
+incdir+rtl/core
rtl/core/dsf_pkg.sv
rtl/core/dsf_bin2bcd.sv
rtl/core/decimal_seven_segment_formatter.sv
verif/decimal_seven_segment_formatter_tb.sv
